// ===== hw/rtl/tprms_pkg.sv =====
// ---------------------------------------------------------------------------
// Touchpad motion scaler package
// Shared types and constants for the relative motion scaler.
// ---------------------------------------------------------------------------
`default_nettype none

package tprms_pkg;

  localparam int unsigned PosWidth     = 16;
  localparam int unsigned DivWidth     = 12;
  localparam int unsigned CarryWidth   = 13;
  // carry + position change needs 18 bits signed; its magnitude fits 17 bits
  localparam int unsigned TotWidth     = 18;
  localparam int unsigned MagWidth     = 17;
  localparam int unsigned DivSteps     = MagWidth;
  localparam int unsigned CntWidth     = $clog2(DivSteps);

  localparam logic [DivWidth-1:0] DefaultDivisor = DivWidth'(64);
  localparam logic [PosWidth-1:0] SatMax         = 16'h7fff;
  localparam logic [PosWidth-1:0] SatMin         = 16'h8000;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StDiv,
    StFix,
    StDone
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/touchpad_relative_motion_scaler_unit.sv =====
// ---------------------------------------------------------------------------
// Touchpad relative motion scaler
// Converts absolute touchpad samples into scaled, saturated relative motion.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sample: touch_i,
//   pos_x_i, pos_y_i. Output channel (out_valid_o / out_stall_i) returns one
//   request per sample: delta_x_o, delta_y_o, surface_active_o.
//   The divisor register is written through cfg_we_i / cfg_wdata_i; the user
//   must write it only while the block is idle, which the block itself does
//   not enforce. Zero selects a divisor of 64. Release and first-touch
//   samples go from accept straight to the done state. A held-touch sample
//   runs a radix-2 restoring divider, one quotient bit per cycle, 17 steps
//   per axis, X then Y, each axis through the load, divide and fix states,
//   before the done state. The done state loads the output register; one
//   sample is in work at a time.
//   in_stall_o is high while a sample is in work. A finished result waits in
//   the output register; if the receiver stalls, the next result holds in the
//   done state until the register frees up.
//   Reset clears the touch state, both remainders and the output valid, and
//   sets the divisor to 64.
// ---------------------------------------------------------------------------
`default_nettype none

module touchpad_relative_motion_scaler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        touch_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] delta_x_o,
  output logic signed [15:0] delta_y_o,
  output logic        surface_active_o
);

  localparam int unsigned PW = tprms_pkg::PosWidth;
  localparam int unsigned DW = tprms_pkg::DivWidth;
  localparam int unsigned CW = tprms_pkg::CarryWidth;
  localparam int unsigned TW = tprms_pkg::TotWidth;
  localparam int unsigned MW = tprms_pkg::MagWidth;
  localparam int unsigned NW = tprms_pkg::CntWidth;

  tprms_pkg::state_e state_q, state_d;

  logic [DW-1:0]        divisor_q;
  logic                 was_touched_q;
  logic signed [PW-1:0] last_x_q, last_y_q;
  logic signed [CW-1:0] carry_x_q, carry_y_q;
  logic signed [TW-1:0] tot_x_q, tot_y_q;
  logic signed [PW-1:0] res_x_q, res_y_q;
  logic                 active_q;
  logic                 axis_q;
  logic                 neg_q;
  logic [MW-1:0]        dq_q;
  logic [DW-1:0]        rem_q;
  logic [NW-1:0]        cnt_q;
  logic                 out_valid_q;

  // control from the FSM
  logic in_accept, load_out;

  logic [DW-1:0] div_eff;
  assign div_eff = (divisor_q == '0) ? tprms_pkg::DefaultDivisor : divisor_q;

  // totals for a held touch: carry + change in position (Y negated)
  logic signed [TW-1:0] tot_x_d, tot_y_d;
  assign tot_x_d = TW'(carry_x_q) + TW'(pos_x_i) - TW'(last_x_q);
  assign tot_y_d = TW'(carry_y_q) - TW'(pos_y_i) + TW'(last_y_q);

  // operand of the current axis, as magnitude
  logic signed [TW-1:0] tot_sel, tot_abs;
  assign tot_sel = axis_q ? tot_y_q : tot_x_q;
  assign tot_abs = tot_sel[TW-1] ? -tot_sel : tot_sel;

  // one restoring step
  logic [DW:0]   trial;
  logic          q_bit;
  logic [DW:0]   trial_sub;
  logic [DW-1:0] rem_step;
  assign trial     = {rem_q, dq_q[MW-1]};
  assign q_bit     = (trial >= {1'b0, div_eff});
  assign trial_sub = trial - {1'b0, div_eff};
  assign rem_step  = q_bit ? trial_sub[DW-1:0] : trial[DW-1:0];

  // sign fix-up and saturation
  logic signed [PW-1:0] q_fix;
  logic signed [CW-1:0] carry_fix;
  logic [CW-1:0]        rem_ext;
  assign rem_ext = {1'b0, rem_q};
  always_comb begin
    if (!neg_q) begin
      q_fix = (dq_q > MW'(tprms_pkg::SatMax)) ? tprms_pkg::SatMax : dq_q[PW-1:0];
    end else begin
      q_fix = (dq_q > MW'(tprms_pkg::SatMin)) ? tprms_pkg::SatMin : -dq_q[PW-1:0];
    end
    carry_fix = neg_q ? -rem_ext : rem_ext;
  end

  // FSM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tprms_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    in_accept  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      tprms_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          in_accept = 1'b1;
          state_d   = (touch_i && was_touched_q) ? tprms_pkg::StLoad : tprms_pkg::StDone;
        end
      end
      tprms_pkg::StLoad: begin
        state_d = tprms_pkg::StDiv;
      end
      tprms_pkg::StDiv: begin
        if (cnt_q == NW'(tprms_pkg::DivSteps - 1)) begin
          state_d = tprms_pkg::StFix;
        end
      end
      tprms_pkg::StFix: begin
        state_d = axis_q ? tprms_pkg::StDone : tprms_pkg::StLoad;
      end
      tprms_pkg::StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = tprms_pkg::StIdle;
        end
      end
      default: begin
        state_d = tprms_pkg::StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q     <= tprms_pkg::DefaultDivisor;
      was_touched_q <= 1'b0;
      carry_x_q     <= '0;
      carry_y_q     <= '0;
      out_valid_q   <= 1'b0;
      axis_q        <= 1'b0;
      cnt_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        divisor_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        axis_q <= 1'b0;
        if (!(touch_i && was_touched_q)) begin
          carry_x_q <= '0;
          carry_y_q <= '0;
        end
        was_touched_q <= touch_i;
      end
      if (state_q == tprms_pkg::StLoad) begin
        cnt_q <= '0;
      end else if (state_q == tprms_pkg::StDiv) begin
        cnt_q <= cnt_q + NW'(1);
      end
      if (state_q == tprms_pkg::StFix) begin
        if (axis_q) begin
          carry_y_q <= carry_fix;
        end else begin
          carry_x_q <= carry_fix;
        end
        axis_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_x_q  <= '0;
      res_y_q  <= '0;
      active_q <= touch_i;
      tot_x_q  <= tot_x_d;
      tot_y_q  <= tot_y_d;
      if (touch_i) begin
        last_x_q <= pos_x_i;
        last_y_q <= pos_y_i;
      end
    end
    case (state_q)
      tprms_pkg::StLoad: begin
        neg_q <= tot_sel[TW-1];
        dq_q  <= tot_abs[MW-1:0];
        rem_q <= '0;
      end
      tprms_pkg::StDiv: begin
        dq_q  <= {dq_q[MW-2:0], q_bit};
        rem_q <= rem_step;
      end
      tprms_pkg::StFix: begin
        if (axis_q) begin
          res_y_q <= q_fix;
        end else begin
          res_x_q <= q_fix;
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      delta_x_o        <= res_x_q;
      delta_y_o        <= res_y_q;
      surface_active_o <= active_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  // a request is taken only once per sample
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a sample is in work");

  // remainders are zero whenever no touch is held
  a_carry_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !was_touched_q |-> (carry_x_q == '0 && carry_y_q == '0))
    else $error("remainder kept without a held touch");

  // output register only loads when free or draining
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");

  // divider step count stays in range
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tprms_pkg::StDiv) |-> (cnt_q < NW'(tprms_pkg::DivSteps)))
    else $error("divider ran past its last step");
`endif

endmodule

`default_nettype wire
